[sv/bpc_pkg.sv]
// Shared types, constants and fixed-point helpers for the barometer compensation block.
// No dependencies.
package bpc_pkg;

    localparam int PRESSURE_FRAC_BITS = 6;
    localparam int TEMP_FRAC_BITS     = 8;
    localparam int Q_T                = 48;
    localparam int Q_W                = 40;
    localparam int STAGES             = 13;
    localparam int CFG_W              = 48;

    localparam logic [1:0] REG_TEMP_TRIM   = 2'd0;
    localparam logic [1:0] REG_PRES_SENS   = 2'd1;
    localparam logic [1:0] REG_PRES_OFFSET = 2'd2;
    localparam logic [1:0] REG_PRES_QUAD   = 2'd3;

    localparam logic [6:0] SH_TQ   = 7'(Q_T - Q_W);
    localparam logic [6:0] SH_TOUT = 7'(Q_T - TEMP_FRAC_BITS);
    localparam logic [6:0] SH_POUT = 7'(Q_W - PRESSURE_FRAC_BITS);
    localparam logic [6:0] SH_QW   = 7'(Q_W);

    localparam logic signed [60:0] TNUM_MIN = -(61'sd50 <<< Q_T);
    localparam logic signed [60:0] TNUM_MAX = 61'sd100 <<< Q_T;
    localparam logic signed [63:0] COMP_MIN = 64'sd30000 <<< Q_W;
    localparam logic signed [63:0] COMP_MAX = 64'sd125000 <<< Q_W;

    typedef struct packed {
        logic [23:0] pressure_raw;
        logic [23:0] temperature_raw;
    } in_t;

    typedef struct packed {
        logic [22:0]        pressure_out;
        logic signed [15:0] temperature_out;
        logic               result_valid;
    } out_t;

    // decoded trim words
    typedef struct packed {
        logic [15:0]        t1;
        logic [15:0]        t2;
        logic signed [7:0]  t3;
        logic signed [16:0] p1s;   // p1 - 2^14
        logic signed [16:0] p2s;   // p2 - 2^14
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } trim_t;

    // wide product split over two stages: sign and four 32x32 partial products
    typedef struct packed {
        logic        neg;
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } parts_t;

    // round(a*b / 2^s) on the magnitude, ties away from zero
    function automatic logic signed [63:0] mul_shr(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input logic [6:0] s);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        logic [127:0] rnd;
        logic [62:0]  r;
        neg  = a[63] ^ b[63];
        ua   = a[63] ? 64'(-a) : 64'(a);
        ub   = b[63] ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        rnd  = prod + (128'd1 << (s - 7'd1));
        r    = 63'(rnd >> s);
        return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    // first half of a wide rounded product
    function automatic parts_t mul_parts(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
        parts_t      p;
        logic [63:0] ua;
        logic [63:0] ub;
        ua    = a[63] ? 64'(-a) : 64'(a);
        ub    = b[63] ? 64'(-b) : 64'(b);
        p.neg = a[63] ^ b[63];
        p.ll  = {32'd0, ua[31:0]} * {32'd0, ub[31:0]};
        p.lh  = {32'd0, ua[31:0]} * {32'd0, ub[63:32]};
        p.hl  = {32'd0, ua[63:32]} * {32'd0, ub[31:0]};
        p.hh  = {32'd0, ua[63:32]} * {32'd0, ub[63:32]};
        return p;
    endfunction

    // second half: sum the partial products, round at bit s, restore the sign
    function automatic logic signed [63:0] parts_round(input parts_t p,
                                                       input logic [6:0] s);
        logic [127:0] sum;
        logic [62:0]  r;
        sum = {64'd0, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0}
            + {p.hh, 64'd0} + (128'd1 << (s - 7'd1));
        r   = 63'(sum >> s);
        return p.neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    // floor((x + 2^(s-1)) / 2^s)
    function automatic logic signed [63:0] round_shr(input logic signed [63:0] x,
                                                     input logic [6:0] s);
        logic signed [63:0] y;
        y = x + $signed(64'd1 << (s - 7'd1));
        return y >>> s;
    endfunction

endpackage

[sv/bpc_trim_regs.sv]
// Trim register file: holds the four calibration words and decodes their fields.
// Depends on bpc_pkg.
module bpc_trim_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [bpc_pkg::CFG_W-1:0]  cfg_wdata,
    output bpc_pkg::trim_t             trim
);

    logic [39:0] temp_trim_reg;
    logic [47:0] sens_trim_reg;
    logic [47:0] offset_trim_reg;
    logic [31:0] quad_trim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg   <= '0;
            sens_trim_reg   <= '0;
            offset_trim_reg <= '0;
            quad_trim_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bpc_pkg::REG_TEMP_TRIM:   temp_trim_reg   <= cfg_wdata[39:0];
                bpc_pkg::REG_PRES_SENS:   sens_trim_reg   <= cfg_wdata[47:0];
                bpc_pkg::REG_PRES_OFFSET: offset_trim_reg <= cfg_wdata[47:0];
                bpc_pkg::REG_PRES_QUAD:   quad_trim_reg   <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        trim.t1  = temp_trim_reg[15:0];
        trim.t2  = temp_trim_reg[31:16];
        trim.t3  = $signed(temp_trim_reg[39:32]);
        trim.p1s = 17'($signed(sens_trim_reg[15:0])) - 17'sd16384;
        trim.p2s = 17'($signed(sens_trim_reg[31:16])) - 17'sd16384;
        trim.p3  = $signed(sens_trim_reg[39:32]);
        trim.p4  = $signed(sens_trim_reg[47:40]);
        trim.p5  = offset_trim_reg[15:0];
        trim.p6  = offset_trim_reg[31:16];
        trim.p7  = $signed(offset_trim_reg[39:32]);
        trim.p8  = $signed(offset_trim_reg[47:40]);
        trim.p9  = $signed(quad_trim_reg[15:0]);
        trim.p10 = $signed(quad_trim_reg[23:16]);
        trim.p11 = $signed(quad_trim_reg[31:24]);
    end

endmodule

[sv/baro_pressure_temp_compensation.sv]
// Barometer compensation top level: trim registers and a thirteen-stage datapath.
// Depends on bpc_pkg and bpc_trim_regs.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one beat per sample: raw
//   pressure and temperature codes. Output channel out_valid/out_ready/out_data
//   returns one beat per sample: pressure in 1/64 Pa, temperature in
//   1/256 degC and a valid flag; both values are zero when the flag is low.
//   Trim words are written through cfg_we/cfg_addr/cfg_wdata while no sample
//   is in flight; a write takes effect on the next clock.
//   A sample passes through the thirteen datapath stages in order. One sample
//   is taken every cycle while the receiver accepts beats, with each wide
//   product split into partial products in one stage and summed and rounded
//   in the next.
//   Each stage moves forward when its successor is empty or moving, so a
//   stalled receiver fills the pipe up to thirteen beats before in_ready
//   drops, and bubbles close up. Nothing is lost or repeated.
//   Reset clears the trim words and all stage valid bits.
module baro_pressure_temp_compensation (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bpc_pkg::in_t               in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bpc_pkg::out_t              out_data,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [bpc_pkg::CFG_W-1:0]  cfg_wdata
);

    bpc_pkg::trim_t trim;

    bpc_trim_regs u_trim (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .trim      (trim)
    );

    // stage control
    logic [bpc_pkg::STAGES-1:0] valid_reg;
    logic [bpc_pkg::STAGES-1:0] valid_next;
    logic [bpc_pkg::STAGES-1:0] en;

    always_comb
    begin
        en[bpc_pkg::STAGES-1] = !valid_reg[bpc_pkg::STAGES-1] || out_ready;
        for (int k = bpc_pkg::STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = in_valid;
        for (int k = 1; k < bpc_pkg::STAGES; k++)
        begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < bpc_pkg::STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[bpc_pkg::STAGES-1];

    // stage 1: dt
    logic signed [24:0] dt_reg, dt_next;
    logic [23:0]        praw1_reg;
    // stage 2: dt*t2, dt^2
    logic signed [41:0] dtt2_reg, dtt2_next;
    logic signed [49:0] dsq_reg, dsq_next;
    logic [23:0]        praw2_reg;
    // stage 3: T in Q48
    logic signed [60:0] tnum_reg, tnum_next;
    logic [23:0]        praw3_reg;
    // stage 4: range check, Q40 temperature, P^2
    logic               tok4_reg, tok4_next;
    logic signed [47:0] tq_reg, tq_next;
    logic [15:0]        tout4_reg, tout4_next;
    logic [47:0]        psq_reg, psq_next;
    logic [23:0]        praw4_reg;
    // stage 5: T^2 partial products, linear terms, quad factor
    bpc_pkg::parts_t    tsq_pp_reg, tsq_pp_next;
    logic signed [63:0] off5_reg, off5_next;
    logic signed [63:0] sens5_reg, sens5_next;
    logic signed [57:0] quad_reg, quad_next;
    logic signed [47:0] tq5_reg;
    logic [47:0]        psq5_reg;
    logic [23:0]        praw5_reg;
    logic               tok5_reg;
    logic [15:0]        tout5_reg;
    // stage 6: T^2, quad*P^2 partial products, p11*P^2
    logic signed [63:0] tsq_reg, tsq_next;
    bpc_pkg::parts_t    qterm_pp_reg, qterm_pp_next;
    logic signed [63:0] cub_reg, cub_next;
    logic signed [63:0] off6_reg;
    logic signed [63:0] sens6_reg;
    logic signed [47:0] tq6_reg;
    logic [23:0]        praw6_reg;
    logic               tok6_reg;
    logic [15:0]        tout6_reg;
    // stage 7: T^3 and cubic-term partial products, square terms
    bpc_pkg::parts_t    tcu_pp_reg, tcu_pp_next;
    bpc_pkg::parts_t    cterm_pp_reg, cterm_pp_next;
    logic signed [63:0] off7_reg, off7_next;
    logic signed [63:0] sens7_reg, sens7_next;
    logic signed [63:0] qterm7_reg, qterm7_next;
    logic [23:0]        praw7_reg;
    logic               tok7_reg;
    logic [15:0]        tout7_reg;
    // stage 8: T^3, cubic pressure term
    logic signed [63:0] tcu_reg, tcu_next;
    logic signed [63:0] cterm_reg, cterm_next;
    logic signed [63:0] off8_reg;
    logic signed [63:0] sens8_reg;
    logic signed [63:0] qterm8_reg;
    logic [23:0]        praw8_reg;
    logic               tok8_reg;
    logic [15:0]        tout8_reg;
    // stage 9: cube terms of off and sens, sum of quad and cubic pressure terms
    logic signed [63:0] off9_reg, off9_next;
    logic signed [63:0] sens9_reg, sens9_next;
    logic signed [63:0] rest9_reg, rest9_next;
    logic [23:0]        praw9_reg;
    logic               tok9_reg;
    logic [15:0]        tout9_reg;
    // stage 10: sens*P partial products, off plus pressure terms
    bpc_pkg::parts_t    sensp_pp_reg, sensp_pp_next;
    logic signed [63:0] base10_reg, base10_next;
    logic               tok10_reg;
    logic [15:0]        tout10_reg;
    // stage 11: sens*P
    logic signed [63:0] sensp_reg, sensp_next;
    logic signed [63:0] base11_reg;
    logic               tok11_reg;
    logic [15:0]        tout11_reg;
    // stage 12: pressure in Q40
    logic signed [63:0] comp_reg, comp_next;
    logic               tok12_reg;
    logic [15:0]        tout12_reg;
    // stage 13: output
    bpc_pkg::out_t      out_reg, out_next;
    logic               pok;

    always_comb
    begin
        dt_next = $signed({1'b0, in_data.temperature_raw})
                - $signed({1'b0, trim.t1, 8'd0});

        dtt2_next = dt_reg * $signed({1'b0, trim.t2});
        dsq_next  = dt_reg * dt_reg;

        tnum_next = (61'(dtt2_reg) <<< 18) + 61'(dsq_reg) * 61'(trim.t3);

        tok4_next  = (tnum_reg >= bpc_pkg::TNUM_MIN) && (tnum_reg <= bpc_pkg::TNUM_MAX);
        tq_next    = 48'(bpc_pkg::round_shr(64'(tnum_reg), bpc_pkg::SH_TQ));
        tout4_next = 16'(bpc_pkg::round_shr(64'(tnum_reg), bpc_pkg::SH_TOUT));
        psq_next   = {24'd0, praw3_reg} * {24'd0, praw3_reg};

        tsq_pp_next = bpc_pkg::mul_parts(64'(tq_reg), 64'(tq_reg));
        off5_next   = $signed(64'(trim.p5) << (bpc_pkg::Q_W + 3))
                    + bpc_pkg::mul_shr(64'(trim.p6), 64'(tq_reg), 7'd6);
        sens5_next  = (64'(trim.p1s) <<< 44)
                    + bpc_pkg::mul_shr(64'(trim.p2s), 64'(tq_reg), 7'd5);
        quad_next   = (58'(trim.p9) <<< bpc_pkg::Q_W) + 58'(trim.p10) * 58'(tq_reg);

        tsq_next      = bpc_pkg::parts_round(tsq_pp_reg, bpc_pkg::SH_QW);
        qterm_pp_next = bpc_pkg::mul_parts(64'(quad_reg), $signed({16'd0, psq5_reg}));
        cub_next      = 64'(trim.p11) * $signed({16'd0, psq5_reg});

        tcu_pp_next   = bpc_pkg::mul_parts(tsq_reg, 64'(tq6_reg));
        cterm_pp_next = bpc_pkg::mul_parts(cub_reg, $signed({40'd0, praw6_reg}));
        off7_next     = off6_reg + bpc_pkg::mul_shr(64'(trim.p7), tsq_reg, 7'd8);
        sens7_next    = sens6_reg + bpc_pkg::mul_shr(64'(trim.p3), tsq_reg, 7'd8);
        qterm7_next   = bpc_pkg::parts_round(qterm_pp_reg, 7'd48);

        tcu_next   = bpc_pkg::parts_round(tcu_pp_reg, bpc_pkg::SH_QW);
        cterm_next = bpc_pkg::parts_round(cterm_pp_reg, 7'd25);

        off9_next  = off8_reg + bpc_pkg::mul_shr(64'(trim.p8), tcu_reg, 7'd15);
        sens9_next = sens8_reg + bpc_pkg::mul_shr(64'(trim.p4), tcu_reg, 7'd13);
        rest9_next = qterm8_reg + cterm_reg;

        sensp_pp_next = bpc_pkg::mul_parts(sens9_reg, $signed({40'd0, praw9_reg}));
        base10_next   = off9_reg + rest9_reg;

        sensp_next = bpc_pkg::parts_round(sensp_pp_reg, 7'd24);

        comp_next = base11_reg + sensp_reg;

        pok = (comp_reg >= bpc_pkg::COMP_MIN) && (comp_reg <= bpc_pkg::COMP_MAX);
        out_next.result_valid    = tok12_reg && pok;
        out_next.pressure_out    = (tok12_reg && pok)
                                 ? 23'(bpc_pkg::round_shr(comp_reg, bpc_pkg::SH_POUT))
                                 : 23'd0;
        out_next.temperature_out = (tok12_reg && pok) ? $signed(tout12_reg) : 16'sd0;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dt_reg    <= dt_next;
            praw1_reg <= in_data.pressure_raw;
        end
        if (en[1])
        begin
            dtt2_reg  <= dtt2_next;
            dsq_reg   <= dsq_next;
            praw2_reg <= praw1_reg;
        end
        if (en[2])
        begin
            tnum_reg  <= tnum_next;
            praw3_reg <= praw2_reg;
        end
        if (en[3])
        begin
            tok4_reg  <= tok4_next;
            tq_reg    <= tq_next;
            tout4_reg <= tout4_next;
            psq_reg   <= psq_next;
            praw4_reg <= praw3_reg;
        end
        if (en[4])
        begin
            tsq_pp_reg <= tsq_pp_next;
            off5_reg   <= off5_next;
            sens5_reg  <= sens5_next;
            quad_reg   <= quad_next;
            tq5_reg    <= tq_reg;
            psq5_reg   <= psq_reg;
            praw5_reg  <= praw4_reg;
            tok5_reg   <= tok4_reg;
            tout5_reg  <= tout4_reg;
        end
        if (en[5])
        begin
            tsq_reg      <= tsq_next;
            qterm_pp_reg <= qterm_pp_next;
            cub_reg      <= cub_next;
            off6_reg     <= off5_reg;
            sens6_reg    <= sens5_reg;
            tq6_reg      <= tq5_reg;
            praw6_reg    <= praw5_reg;
            tok6_reg     <= tok5_reg;
            tout6_reg    <= tout5_reg;
        end
        if (en[6])
        begin
            tcu_pp_reg   <= tcu_pp_next;
            cterm_pp_reg <= cterm_pp_next;
            off7_reg     <= off7_next;
            sens7_reg    <= sens7_next;
            qterm7_reg   <= qterm7_next;
            praw7_reg    <= praw6_reg;
            tok7_reg     <= tok6_reg;
            tout7_reg    <= tout6_reg;
        end
        if (en[7])
        begin
            tcu_reg    <= tcu_next;
            cterm_reg  <= cterm_next;
            off8_reg   <= off7_reg;
            sens8_reg  <= sens7_reg;
            qterm8_reg <= qterm7_reg;
            praw8_reg  <= praw7_reg;
            tok8_reg   <= tok7_reg;
            tout8_reg  <= tout7_reg;
        end
        if (en[8])
        begin
            off9_reg  <= off9_next;
            sens9_reg <= sens9_next;
            rest9_reg <= rest9_next;
            praw9_reg <= praw8_reg;
            tok9_reg  <= tok8_reg;
            tout9_reg <= tout8_reg;
        end
        if (en[9])
        begin
            sensp_pp_reg <= sensp_pp_next;
            base10_reg   <= base10_next;
            tok10_reg    <= tok9_reg;
            tout10_reg   <= tout9_reg;
        end
        if (en[10])
        begin
            sensp_reg  <= sensp_next;
            base11_reg <= base10_reg;
            tok11_reg  <= tok10_reg;
            tout11_reg <= tout10_reg;
        end
        if (en[11])
        begin
            comp_reg   <= comp_next;
            tok12_reg  <= tok11_reg;
            tout12_reg <= tout11_reg;
        end
        if (en[12])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule
